@@ hdl/f64mf_pkg.sv @@
// ----------------------------------------------------------------------------
// f64mf_pkg
// Shared constants for the binary64 integral/fraction split.
// ----------------------------------------------------------------------------
`default_nettype none

package f64mf_pkg;

    localparam int MANT_W = 52;
    localparam int EXP_W  = 11;
    localparam int WORD_W = 64;
    localparam logic [EXP_W-1:0] EXP_BIAS = 11'd1023;
    localparam logic [EXP_W-1:0] EXP_BIG  = 11'd1075;   // bias + 52

    // position of the highest set bit in a 52-bit fraction field
    function automatic logic [5:0] top_bit(input logic [MANT_W-1:0] x);
        logic [5:0] p;
        p = 6'd0;
        for (int i = 0; i < MANT_W; i++)
        begin
            if (x[i])
                p = 6'(i);
        end
        return p;
    endfunction

endpackage

`default_nettype wire

@@ hdl/float64_modf.sv @@
// ----------------------------------------------------------------------------
// float64_modf
// Splits a binary64 value into its integral and fractional parts.
// ----------------------------------------------------------------------------
// A request is taken whenever start is high; busy stays low, so one operand
// can enter every cycle. The result passes through the input register and then
// the result register, and is marked by done for exactly one cycle. The
// receiver cannot stall, so results must be taken as shown.
`default_nettype none

module float64_modf
    import f64mf_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [WORD_W-1:0] value_bits,
    output logic                   done,
    output logic [WORD_W-1:0]      integral_bits,
    output logic [WORD_W-1:0]      fraction_bits
);

    logic              in_vld_reg;
    logic [WORD_W-1:0] in_reg;
    logic              out_vld_reg;
    logic [WORD_W-1:0] int_reg, int_next;
    logic [WORD_W-1:0] frac_reg, frac_next;

    logic [EXP_W-1:0]  exp_f;
    logic [5:0]        e;       // unbiased exponent when in 0..51
    logic [5:0]        cut;
    logic [MANT_W:0]   below;
    logic [MANT_W:0]   low;
    logic [5:0]        p;
    logic [EXP_W-1:0]  new_exp;
    logic [MANT_W-1:0] new_mant;

    assign busy = 1'b0;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else
            in_vld_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        if (start)
            in_reg <= value_bits;
    end

    // split datapath
    always_comb
    begin
        exp_f    = in_reg[WORD_W-2 -: EXP_W];
        e        = 6'(exp_f - EXP_BIAS);
        cut      = 6'(MANT_W) - e;
        below    = (MANT_W+1)'(({{MANT_W{1'b0}}, 1'b1} << cut) - 1'b1);
        low      = {1'b1, in_reg[MANT_W-1:0]} & below;
        p        = top_bit(low[MANT_W-1:0]);
        new_exp  = exp_f - EXP_W'(MANT_W) + EXP_W'(p);
        new_mant = MANT_W'(low[MANT_W-1:0] << (6'(MANT_W) - p));
        if (exp_f < EXP_BIAS)
        begin
            int_next  = '0;
            frac_next = in_reg;
        end
        else if (exp_f >= EXP_BIG)
        begin
            int_next  = in_reg;
            frac_next = '0;
        end
        else
        begin
            int_next = in_reg & ~{{(WORD_W-MANT_W-1){1'b0}}, below};
            if (low == '0)
                frac_next = '0;
            else
                frac_next = {in_reg[WORD_W-1], new_exp, new_mant};
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else
            out_vld_reg <= in_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (in_vld_reg)
        begin
            int_reg  <= int_next;
            frac_reg <= frac_next;
        end
    end

    assign done          = out_vld_reg;
    assign integral_bits = int_reg;
    assign fraction_bits = frac_reg;

    // checks
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> ##1 done) else $error("result missing two cycles after request");
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 2)) else $error("result without request");
    a_parts: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg && exp_f >= EXP_BIG |=> frac_reg == '0)
        else $error("large value left a fraction");

endmodule

`default_nettype wire

@@ tb/float64_modf_tb.sv @@
// ----------------------------------------------------------------------------
// float64_modf_tb
// Self-checking bench for the binary64 integral/fraction split: directed
// corner values, exponent sweeps and random patterns, with results checked
// against an in-bench bit-level model of the split.
// ----------------------------------------------------------------------------
`default_nettype none

module float64_modf_tb;
    import f64mf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [WORD_W-1:0] integral;
        logic [WORD_W-1:0] fraction;
    } split_t;

    localparam int WATCHDOG_LIMIT = 2000;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [WORD_W-1:0] value_bits;
    logic              done;
    logic [WORD_W-1:0] integral_bits;
    logic [WORD_W-1:0] fraction_bits;

    split_t split_q[$];
    int     mismatches;
    int     results_seen;
    int     requests_sent;
    int     idle_cycles;

    float64_modf u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .value_bits    (value_bits),
        .done          (done),
        .integral_bits (integral_bits),
        .fraction_bits (fraction_bits)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // bit-level split of one binary64 value
    function automatic split_t split_value(input logic [63:0] v);
        split_t         r;
        int             e;
        int             cut;
        int             p;
        logic [63:0]    below;
        logic [63:0]    low;
        logic [10:0]    new_exp;
        e = int'(v[62:52]) - 1023;
        if (e < 0)
        begin
            r.integral = '0;
            r.fraction = v;
        end
        else if (e >= 52)
        begin
            r.integral = v;
            r.fraction = '0;
        end
        else
        begin
            cut = 52 - e;
            below = (64'd1 << cut) - 64'd1;
            low = {12'd1, v[51:0]} & below;
            r.integral = v & ~below;
            if (low == '0)
                r.fraction = '0;
            else
            begin
                p = 0;
                for (int i = 0; i < 64; i++)
                    if (low[i])
                        p = i;
                new_exp = 11'(e - 52 + p + 1023);
                r.fraction = {v[63], new_exp, 52'((low << (52 - p)))};
            end
        end
        return r;
    endfunction

    // send one request with a random lead-in gap; start stays high afterwards
    // so that requests can follow back to back
    task automatic send_value(input logic [63:0] v);
        int gap;
        gap = $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            value_bits <= {$urandom, $urandom};
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        value_bits <= v;
        do @(posedge clk); while (busy);
        split_q.push_back(split_value(v));
        requests_sent++;
        @(negedge clk);
    endtask

    // drop start after the last request of a sequence
    task automatic stop_sending();
        start <= 1'b0;
        value_bits <= {$urandom, $urandom};
    endtask

    // random value with a chosen unbiased exponent
    function automatic logic [63:0] with_exp(input int e);
        logic [63:0] v;
        v = {$urandom, $urandom};
        v[62:52] = 11'(e + 1023);
        return v;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        split_t want;
        if (rst_n && done)
        begin
            results_seen <= results_seen + 1;
            if (split_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result int=%h frac=%h", integral_bits, fraction_bits);
            end
            else
            begin
                want = split_q.pop_front();
                if (integral_bits !== want.integral || fraction_bits !== want.fraction)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: int exp %h got %h, frac exp %h got %h",
                                 want.integral, integral_bits, want.fraction, fraction_bits);
                end
            end
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if ((start && !busy) || done || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired");
            $display("Regression FAIL");
            $finish;
        end
    end

    // corners: zeros, subnormals, ones, infinities, nans, boundaries
    task automatic test_directed();
        logic [63:0] vals[$];
        vals = '{64'h0000000000000000, 64'h8000000000000000, 64'h0000000000000001,
                 64'h800FFFFFFFFFFFFF, 64'h3FEFFFFFFFFFFFFF, 64'h3FF0000000000000,
                 64'hBFF0000000000000, 64'h3FFFFFFFFFFFFFFF, 64'hBFF8000000000000,
                 64'h4330000000000000, 64'h432FFFFFFFFFFFFF, 64'hC32FFFFFFFFFFFFF,
                 64'h4330000000000001, 64'h7FF0000000000000, 64'hFFF0000000000000,
                 64'h7FF8000000000000, 64'hFFFFFFFFFFFFFFFF, 64'h7FEFFFFFFFFFFFFF,
                 64'h4000000000000001, 64'hC00921FB54442D18, 64'h400C000000000000,
                 64'hFFFFFFFFFFFFFFFE, 64'h432FFFFFFFFFFFFE};
        foreach (vals[i])
            send_value(vals[i]);
    endtask

    // every exponent from -2 to 54, covering the split range, with random signs
    task automatic test_exponent_sweep();
        for (int e = -2; e <= 54; e++)
            send_value(with_exp(e));
    endtask

    // let the pipeline drain fully, then send 20 more requests
    task automatic test_drain_pause();
        stop_sending();
        wait (split_q.size() == 0);
        repeat (4) @(negedge clk);
        for (int i = 0; i < 20; i++)
            send_value(with_exp($urandom_range(0, 52)));
    endtask

    // random mix weighted toward the interesting exponent range
    task automatic test_random();
        logic [63:0] v;
        for (int i = 0; i < 700; i++)
        begin
            case ($urandom_range(0, 9))
                0, 1: v = {$urandom, $urandom};
                2:    v = with_exp($urandom_range(0, 4) - 5);
                3:    v = with_exp($urandom_range(52, 1024));
                4:
                begin
                    // whole number: clear the fraction bits
                    v = with_exp($urandom_range(0, 51));
                    v = v & ~((64'd1 << (52 - (int'(v[62:52]) - 1023))) - 64'd1);
                end
                default: v = with_exp($urandom_range(0, 51));
            endcase
            send_value(v);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        value_bits = '0;
        mismatches = 0;
        results_seen = 0;
        requests_sent = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_exponent_sweep();
        test_drain_pause();
        test_random();
        stop_sending();

        wait (split_q.size() == 0);
        repeat (10) @(posedge clk);
        $display("covered %0d requests, %0d results: corners, exponent sweep, random mix",
                 requests_sent, results_seen);
        if (mismatches == 0 && split_q.size() == 0)
            $display("Regression PASS");
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
